// ----- design/mctt_pkg.sv -----
// Package for the MIDI clock tempo tracker: message codes, field types,
// reset values and configuration register indexes. No dependencies.
package mctt_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] bpm_t;
  typedef logic [1:0]  mult_t;
  typedef logic [1:0]  xport_t;

  // System real-time status codes
  localparam byte_t ST_CLOCK    = 8'hF8;
  localparam byte_t ST_START    = 8'hFA;
  localparam byte_t ST_CONTINUE = 8'hFB;
  localparam byte_t ST_STOP     = 8'hFC;

  // Channel message classes (upper nibble of the status byte)
  localparam logic [3:0] CLS_NOTE_ON = 4'h9;
  localparam logic [3:0] CLS_CTRL    = 4'hB;

  localparam byte_t NOTE_X1   = 8'd60;
  localparam byte_t NOTE_HALF = 8'd61;
  localparam byte_t NOTE_X2   = 8'd62;
  localparam byte_t CC_TEMPO  = 8'd20;

  localparam mult_t MULT_X1   = 2'd0;
  localparam mult_t MULT_HALF = 2'd1;
  localparam mult_t MULT_X2   = 2'd2;

  localparam logic KIND_TRANSPORT = 1'b0;
  localparam logic KIND_UPDATE    = 1'b1;

  localparam xport_t XPORT_NONE = 2'd0;

  localparam logic [1:0] LEN_EMPTY = 2'd0;
  localparam logic [1:0] LEN_FULL  = 2'd3;

  localparam bpm_t BPM_RESET    = 16'd120;
  localparam bpm_t BPM_MAX      = 16'hFFFF;
  localparam bpm_t TEMPO_OFFSET = 16'd60;

  localparam int unsigned DELTA_W = 20;
  localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

  // 60e6 / 24 ticks per beat, doubled for round-half-up
  localparam int unsigned SCALE_W = 23;
  localparam logic [SCALE_W-1:0] BPM_SCALE = 23'd5000000;

  localparam int unsigned MIN_TICKS_W = 5;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;
  localparam logic [MIN_TICKS_W-1:0] MIN_TICKS_RESET = 5'd6;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS = 1'b1;

endpackage

// ----- design/mctt_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mctt_ram #(
  parameter int WIDTH  = 20,
  parameter int DEPTH  = 24,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/mctt_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies; used by the tempo tracker for the tempo estimate.
module mctt_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] work;
  logic [CNT_W-1:0] steps;
  logic             busy;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           fits;

  // shift in the next dividend bit, subtract if the divisor fits
  always_comb begin
    rem_sh = {rem, work[NUM_W-1]};
    diff   = rem_sh - {1'b0, den};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(NUM_W);
        den   <= denom;
        rem   <= '0;
        work  <= numer;
      end else if (busy) begin
        rem   <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        work  <= {work[NUM_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = work;

endmodule

// ----- design/midi_clock_tempo_tracker.sv -----
// MIDI clock tempo tracker, top level: message decode, tick window sequencer
// and output register. Depends on mctt_pkg, mctt_ram and mctt_div.
//
// Empty, short and unknown words retire without leaving the idle state;
// transport, note and controller words go through the output state to the
// output register. A tick that reaches an estimate goes through the push,
// evict (if full), check, divide and (on a change) output states; the
// divider makes one quotient bit per cycle. One word is in work at a time.
// Reset (rst, synchronous): tempo 120, multiplier x1, empty window, waiting
// for a first tick, timeout 1000000 us, min ticks 6. The delta RAM is not
// cleared; entries are read only after the window has filled them.
module midi_clock_tempo_tracker #(
  parameter int WINDOW_LEN = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input message words
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mctt_pkg::byte_t                        status_byte,
  input  mctt_pkg::byte_t                        data_one,
  input  mctt_pkg::byte_t                        data_two,
  input  logic [1:0]                             msg_len,
  input  logic [31:0]                            stamp_us,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   event_kind,
  output mctt_pkg::xport_t                       transport_code,
  output mctt_pkg::bpm_t                         bpm,
  output mctt_pkg::mult_t                        mult_code,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mctt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [31:0]                            cfg_data
);

  import mctt_pkg::*;

  // Widths that follow from the window length
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W  = DELTA_W + CNT_W;
  localparam int DEN_W  = SUM_W + 1;
  localparam int NUM_W  = SCALE_W + 1 + CNT_W;
  localparam int CMP_W  = (CNT_W > MIN_TICKS_W) ? CNT_W : MIN_TICKS_W;
  localparam int SLOT_W = CNT_W + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_EVICT = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;

  // Configuration registers
  logic [31:0]            timeout_us;
  logic [MIN_TICKS_W-1:0] min_ticks;

  // Tracker state
  logic [AW-1:0]    ring_head;
  logic [CNT_W-1:0] ring_count;
  logic [SUM_W-1:0] window_sum;
  logic [31:0]      last_stamp;
  logic             awaiting_first;
  bpm_t             tempo_now;
  mult_t            mult_now;

  // Work registers
  logic [DELTA_W-1:0] delta_hold;
  logic               pend_kind;
  xport_t             pend_code;

  // Decode of the incoming word
  logic        accept;
  logic        is_transport;
  logic        is_tick;
  logic        is_note_on;
  logic        is_tempo_cc;
  logic [31:0] delta_raw;
  logic        tick_timeout;
  logic        window_full;
  logic [SLOT_W-1:0] slot_raw;
  logic [AW-1:0]     slot;
  logic        out_free;
  logic        below_min;

  // RAM and divider hookups
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [DELTA_W-1:0] ram_rd_data;
  logic               div_start;
  logic [NUM_W-1:0]   div_numer;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  bpm_t               est_bpm;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    is_transport = (status_byte == ST_START) || (status_byte == ST_CONTINUE)
                || (status_byte == ST_STOP);
    is_tick      = (status_byte == ST_CLOCK);
    is_note_on   = (status_byte[7:4] == CLS_NOTE_ON) && (data_two != '0);
    is_tempo_cc  = (status_byte[7:4] == CLS_CTRL) && (data_one == CC_TEMPO);
    delta_raw    = stamp_us - last_stamp;
    tick_timeout = delta_raw > timeout_us;
  end

  // Ring slot for an append: head + count, wrapped once
  always_comb begin
    window_full = (ring_count == CNT_W'(WINDOW_LEN));
    slot_raw    = SLOT_W'(ring_head) + SLOT_W'(ring_count);
    if (slot_raw >= SLOT_W'(WINDOW_LEN)) begin
      slot = AW'(slot_raw - SLOT_W'(WINDOW_LEN));
    end else begin
      slot = AW'(slot_raw);
    end
    below_min = CMP_W'(ring_count) < CMP_W'(min_ticks);
  end

  // Append writes the next free slot; a full window overwrites the oldest
  assign ram_wr_en   = ((state == S_PUSH) && !window_full) || (state == S_EVICT);
  assign ram_wr_addr = (state == S_EVICT) ? ring_head : slot;

  mctt_ram #(
    .WIDTH  (DELTA_W),
    .DEPTH  (WINDOW_LEN),
    .ADDR_W (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (delta_hold),
    .rd_addr (ring_head),
    .rd_data (ram_rd_data)
  );

  // Numerator 5e6*count + sum, denominator 2*sum: quotient rounds half up
  assign div_start = (state == S_CHECK) && !below_min && (window_sum != '0);
  assign div_numer = NUM_W'(ring_count) * NUM_W'(BPM_SCALE) + NUM_W'(window_sum);

  mctt_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom ({window_sum, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Saturate the quotient to the tempo range
  assign est_bpm = (div_quot > NUM_W'(BPM_MAX)) ? BPM_MAX : div_quot[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      timeout_us     <= TIMEOUT_RESET;
      min_ticks      <= MIN_TICKS_RESET;
      ring_head      <= '0;
      ring_count     <= '0;
      window_sum     <= '0;
      last_stamp     <= '0;
      awaiting_first <= 1'b1;
      tempo_now      <= BPM_RESET;
      mult_now       <= MULT_X1;
      out_valid      <= 1'b0;
    end else begin
      // Register writes land only while the sequencer is idle
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TIMEOUT:   timeout_us <= cfg_data;
          REG_MIN_TICKS: min_ticks  <= cfg_data[MIN_TICKS_W-1:0];
          default:       ;
        endcase
      end

      // Drop the output word once taken, unless a new one is loaded below
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (msg_len != LEN_EMPTY)) begin
            if (is_transport) begin
              // Clear the window and re-arm the first-tick baseline
              ring_head      <= '0;
              ring_count     <= '0;
              window_sum     <= '0;
              awaiting_first <= 1'b1;
              pend_kind      <= KIND_TRANSPORT;
              pend_code      <= xport_t'(status_byte - ST_START);
              state          <= S_OUT;
            end else if (is_tick) begin
              last_stamp <= stamp_us;
              if (awaiting_first) begin
                awaiting_first <= 1'b0;
              end else if (tick_timeout) begin
                ring_head  <= '0;
                ring_count <= '0;
                window_sum <= '0;
              end else begin
                // Hold the gap, saturated to the stored width
                delta_hold <= (delta_raw > 32'(DELTA_MAX)) ? DELTA_MAX
                                                           : delta_raw[DELTA_W-1:0];
                state      <= S_PUSH;
              end
            end else if (msg_len == LEN_FULL) begin
              if (is_note_on) begin
                pend_kind <= KIND_UPDATE;
                pend_code <= XPORT_NONE;
                case (data_one)
                  NOTE_X1: begin
                    mult_now <= MULT_X1;
                    state    <= S_OUT;
                  end
                  NOTE_HALF: begin
                    mult_now <= MULT_HALF;
                    state    <= S_OUT;
                  end
                  NOTE_X2: begin
                    mult_now <= MULT_X2;
                    state    <= S_OUT;
                  end
                  default: ;
                endcase
              end else if (is_tempo_cc) begin
                tempo_now <= bpm_t'(data_two) + TEMPO_OFFSET;
                pend_kind <= KIND_UPDATE;
                pend_code <= XPORT_NONE;
                state     <= S_OUT;
              end
            end
          end
        end

        S_PUSH: begin
          if (window_full) begin
            // Oldest entry is read out this cycle, swap it next
            state <= S_EVICT;
          end else begin
            ring_count <= ring_count + 1'b1;
            window_sum <= window_sum + SUM_W'(delta_hold);
            state      <= S_CHECK;
          end
        end

        S_EVICT: begin
          window_sum <= window_sum - SUM_W'(ram_rd_data) + SUM_W'(delta_hold);
          ring_head  <= (ring_head == AW'(WINDOW_LEN - 1)) ? '0 : ring_head + 1'b1;
          state      <= S_CHECK;
        end

        S_CHECK: begin
          pend_kind <= KIND_UPDATE;
          pend_code <= XPORT_NONE;
          if (below_min) begin
            state <= S_IDLE;
          end else if (window_sum == '0) begin
            // Zero mean gap: saturate the tempo
            if (tempo_now == BPM_MAX) begin
              state <= S_IDLE;
            end else begin
              tempo_now <= BPM_MAX;
              state     <= S_OUT;
            end
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            if (est_bpm == tempo_now) begin
              state <= S_IDLE;
            end else begin
              tempo_now <= est_bpm;
              state     <= S_OUT;
            end
          end
        end

        S_OUT: begin
          // Wait for the output register to free up, then load it
          if (out_free) begin
            out_valid      <= 1'b1;
            event_kind     <= pend_kind;
            transport_code <= pend_code;
            bpm            <= tempo_now;
            mult_code      <= mult_now;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The window never holds more entries than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CNT_W'(WINDOW_LEN))
    else $error("window count beyond window length");

  // An empty window carries no sum
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (ring_count == '0) |-> (window_sum == '0))
    else $error("window sum nonzero on empty window");

  // The divider only finishes while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside of divide state");

  // A transport word empties the window and heads for the output
  a_transport: assert property (@(posedge clk) disable iff (rst)
    (accept && (msg_len != LEN_EMPTY) && is_transport)
      |=> ((state == S_OUT) && (ring_count == '0) && awaiting_first))
    else $error("transport word did not clear the window");

  // A divider start always moves the sequencer into the divide state
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIV))
    else $error("divider started outside of the estimate path");

endmodule
